>>> sv/bed_pkg.sv
// Shared types and constants for the button event detector.
// Depends on nothing; imported by the top level.
package bed_pkg;

  // Debounce window: pressed once the counter reaches Window, saturates at 2*Window-1.
  localparam int Window = 4;
  localparam int DbW    = $clog2(2 * Window);
  localparam int DbTop  = 2 * Window - 1;

  // Event queue depth and its pointer/count widths.
  localparam int QDepth = 4;
  localparam int QPtrW  = $clog2(QDepth);
  localparam int QCntW  = $clog2(QDepth + 1);

  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 32;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACTIVE_LEVEL = 2'd0,
    CFG_TICK_STEP    = 2'd1,
    CFG_LONG_THRESH  = 2'd2,
    CFG_CLICK_TMO    = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    EV_DOWN         = 3'd0,
    EV_UP           = 3'd1,
    EV_LONG_START   = 3'd2,
    EV_LONG_HOLD    = 3'd3,
    EV_LONG_RELEASE = 3'd4,
    EV_SINGLE       = 3'd5,
    EV_DOUBLE       = 3'd6,
    EV_MULTI        = 3'd7
  } event_code_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HELD = 2'd1,
    PH_WAIT = 2'd2
  } phase_e;

  typedef struct packed {
    event_code_e code;
    logic [7:0]  clicks;
    logic        last;
  } event_t;

endpackage

>>> sv/button_event_detector.sv
// Top level of the button event detector: debounce, press timing and click decode.
// Depends on bed_pkg for event codes, phase encoding and queue sizing.

// Button event detector. Each request on the input channel carries one raw pin
// sample; the block advances its own 32-bit tick by tick_step, debounces the
// level with a saturating up/down counter, and reports down, up, long start,
// long hold, long release and single/double/multiple click events on the output
// channel, at most two per sample, the final one flagged by last_o. A sample is
// taken in a cycle in which it is offered and in_ready_o is high, and is fully
// processed in that cycle: state updates and its events land in a four-entry
// event queue. The queue drains one event per cycle while out_ready_i is high,
// so the input accepts a sample every cycle as long as the queue holds two
// entries or fewer; samples yielding one event or none run at one per cycle,
// and two-event samples outrun the single-event read port until in_ready_o
// stalls them. cfg_we_i writes take effect on the next cycle; no read-back.
module button_event_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bed_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [bed_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         level_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [2:0]                   event_code_o,
  output logic [7:0]                   click_total_o,
  output logic                         last_o
);
  import bed_pkg::*;

  // Configuration registers.
  logic        active_level_q;
  logic [15:0] tick_step_q;
  logic [31:0] long_thresh_q;
  logic [31:0] click_tmo_q;

  // Detector state.
  logic [31:0]    tick_q, tick_d;
  logic [DbW-1:0] db_q, db_d;
  phase_e         phase_q, phase_d;
  logic           long_q, long_d;
  logic [31:0]    down_q, down_d;
  logic [31:0]    up_q, up_d;
  logic [7:0]     clicks_q, clicks_d;

  // Event queue.
  event_t           q_mem [QDepth];
  logic [QPtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCntW-1:0] cnt_q, cnt_d;

  logic        accept, pop, pressed;
  logic [1:0]  n_ev;
  event_t      ev0, ev1;
  logic [31:0] held_time, rel_time;

  assign accept     = in_valid_i && in_ready_o;
  assign pop        = out_valid_o && out_ready_i;
  // Take a new sample only while the queue has room for two events.
  assign in_ready_o = (cnt_q <= QCntW'(QDepth - 2));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_level_q <= 1'b0;
      tick_step_q    <= 16'd10;
      long_thresh_q  <= 32'd1000;
      click_tmo_q    <= 32'd300;
    end else if (cfg_we_i) begin
      case (cfg_index_e'(cfg_index_i))
        CFG_ACTIVE_LEVEL: active_level_q <= cfg_data_i[0];
        CFG_TICK_STEP:    tick_step_q    <= cfg_data_i[15:0];
        CFG_LONG_THRESH:  long_thresh_q  <= cfg_data_i;
        CFG_CLICK_TMO:    click_tmo_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the tick and the debounce counter for this sample.
  always_comb begin
    tick_d = tick_q + {16'd0, tick_step_q};
    db_d   = db_q;
    if (level_i == active_level_q) begin
      if (db_q < DbW'(DbTop)) db_d = db_q + DbW'(1);
    end else if (db_q != '0) begin
      db_d = db_q - DbW'(1);
    end
    pressed   = (db_d >= DbW'(Window));
    held_time = tick_d - down_q;
    rel_time  = tick_d - up_q;
  end

  // Phase transitions and the events they raise.
  always_comb begin
    phase_d  = phase_q;
    long_d   = long_q;
    down_d   = down_q;
    up_d     = up_q;
    clicks_d = clicks_q;
    n_ev     = 2'd0;
    ev0      = '{code: EV_DOWN, clicks: clicks_q, last: 1'b0};
    ev1      = '{code: EV_DOWN, clicks: clicks_q, last: 1'b0};
    if (pressed) begin
      case (phase_q)
        PH_IDLE, PH_WAIT: begin
          down_d = tick_d;
          if (clicks_q != 8'hFF) clicks_d = clicks_q + 8'd1;
          ev0.code = EV_DOWN;
          n_ev     = 2'd1;
          phase_d  = PH_HELD;
        end
        PH_HELD: begin
          if (held_time > long_thresh_q) begin
            if (!long_q) begin
              ev0.code = EV_LONG_START;
              ev1.code = EV_LONG_HOLD;
              n_ev     = 2'd2;
              long_d   = 1'b1;
            end else begin
              ev0.code = EV_LONG_HOLD;
              n_ev     = 2'd1;
            end
          end
        end
        default: ;  // unused phase: hold everything
      endcase
    end else begin
      case (phase_q)
        PH_HELD: begin
          up_d     = tick_d;
          ev0.code = EV_UP;
          ev1.code = EV_LONG_RELEASE;
          n_ev     = long_q ? 2'd2 : 2'd1;
          phase_d  = PH_WAIT;
          down_d   = '0;
        end
        PH_WAIT: begin
          if (rel_time > click_tmo_q) begin
            // A flagged long press suppresses the click report.
            if (!long_q) begin
              if (clicks_q == 8'd1) begin
                ev0.code = EV_SINGLE;
                n_ev     = 2'd1;
              end else if (clicks_q == 8'd2) begin
                ev0.code = EV_DOUBLE;
                n_ev     = 2'd1;
              end else if (clicks_q > 8'd2) begin
                ev0.code = EV_MULTI;
                n_ev     = 2'd1;
              end
            end
            up_d     = '0;
            clicks_d = '0;
            phase_d  = PH_IDLE;
          end
        end
        default: begin
          phase_d = PH_IDLE;
          long_d  = 1'b0;
        end
      endcase
    end
    // Down reports the count after this press; every other event the count it sees.
    if (!(phase_q == PH_WAIT && !pressed)) begin
      ev0.clicks = clicks_d;
      ev1.clicks = clicks_d;
    end
    ev0.last = (n_ev == 2'd1);
    ev1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      db_q     <= '0;
      phase_q  <= PH_IDLE;
      long_q   <= 1'b0;
      down_q   <= '0;
      up_q     <= '0;
      clicks_q <= '0;
    end else if (accept) begin
      tick_q   <= tick_d;
      db_q     <= db_d;
      phase_q  <= phase_d;
      long_q   <= long_d;
      down_q   <= down_d;
      up_q     <= up_d;
      clicks_q <= clicks_d;
    end
  end

  // Queue occupancy: push up to two, pop one.
  always_comb begin
    cnt_d = cnt_q;
    if (accept) cnt_d = cnt_d + QCntW'(n_ev);
    if (pop)    cnt_d = cnt_d - QCntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (accept) wr_ptr_q <= wr_ptr_q + QPtrW'(n_ev);
      if (pop)    rd_ptr_q <= rd_ptr_q + QPtrW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && n_ev != 2'd0) q_mem[wr_ptr_q] <= ev0;
    if (accept && n_ev == 2'd2) q_mem[wr_ptr_q + QPtrW'(1)] <= ev1;
  end

  assign out_valid_o   = (cnt_q != '0);
  assign event_code_o  = q_mem[rd_ptr_q].code;
  assign click_total_o = q_mem[rd_ptr_q].clicks;
  assign last_o        = q_mem[rd_ptr_q].last;

`ifndef SYNTH
  a_q_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QDepth))
    else $error("event queue overflow");

  a_ready_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (cnt_q <= QCntW'(QDepth - 2)))
    else $error("sample accepted without room for two events");

  a_db_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    db_q <= DbW'(DbTop))
    else $error("debounce counter beyond saturation");

  a_ptr_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) == QPtrW'(cnt_q))
    else $error("queue pointers disagree with count");

  a_held_stamp : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && phase_q == PH_HELD && !pressed) |=> (down_q == '0 && phase_q == PH_WAIT))
    else $error("release did not clear down stamp");
`endif

endmodule
